// ----- design/gtsm_pkg.sv -----
// ----------------------------------------------------------------------------
// gtsm_pkg: gate travel state machine shared types
// Event, result and configuration words, code enums and reset values.
// ----------------------------------------------------------------------------
package gtsm_pkg;

  localparam int unsigned TimeW   = 32;
  localparam int unsigned CfgIdxW = 2;

  typedef enum logic [1:0] {
    CmdOpen   = 2'd0,
    CmdClose  = 2'd1,
    CmdStatus = 2'd2,
    CmdTick   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ResAccepted   = 2'd0,
    ResIdempotent = 2'd1,
    ResThrottled  = 2'd2,
    ResNone       = 2'd3
  } res_e;

  typedef enum logic [2:0] {
    PosUnknown = 3'd0,
    PosClosed  = 3'd1,
    PosOpening = 3'd2,
    PosOpen    = 3'd3,
    PosClosing = 3'd4,
    PosStopped = 3'd5
  } pos_e;

  typedef enum logic [1:0] {
    LastNone  = 2'd0,
    LastOpen  = 2'd1,
    LastClose = 2'd2
  } last_e;

  typedef logic [TimeW-1:0] time_t;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgMinSpacing    = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CfgTravelTimeout = CfgIdxW'(1);

  localparam time_t MinSpacingRst    = TimeW'(1000);
  localparam time_t TravelTimeoutRst = TimeW'(30000);

  typedef struct packed {
    cmd_e  command;
    logic  fully_open;
    time_t now_time;
  } evt_t;

  typedef struct packed {
    res_e  cmd_result;
    pos_e  gate_state;
    last_e last_command;
    time_t last_command_time;
  } res_t;

  typedef struct packed {
    logic [CfgIdxW-1:0] index;
    time_t              value;
  } cfg_wr_t;

  typedef struct packed {
    time_t min_cmd_spacing;
    time_t travel_timeout;
  } cfg_t;

endpackage

// ----- design/gtsm_chan_if.sv -----
// ----------------------------------------------------------------------------
// gtsm_chan_if: valid/ready channel
// Carries one word of a given payload type per handshake.
// ----------------------------------------------------------------------------
interface gtsm_chan_if #(
  parameter type payload_t = logic
);

  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);

endinterface

// ----- design/gtsm_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// gtsm_cfg_regs: configuration registers
// Holds command spacing and travel timeout; unknown indexes are dropped.
// ----------------------------------------------------------------------------
module gtsm_cfg_regs (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_en_i,
  input  gtsm_pkg::cfg_wr_t wr_i,
  output gtsm_pkg::cfg_t    cfg_o
);
  import gtsm_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en_i) begin
      case (wr_i.index)
        CfgMinSpacing:    cfg_d.min_cmd_spacing = wr_i.value;
        CfgTravelTimeout: cfg_d.travel_timeout  = wr_i.value;
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_cmd_spacing <= MinSpacingRst;
      cfg_q.travel_timeout  <= TravelTimeoutRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- design/gtsm_core.sv -----
// ----------------------------------------------------------------------------
// gtsm_core: gate position update
// Applies one event word to the gate state and forms its result word.
// ----------------------------------------------------------------------------
module gtsm_core (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            step_i,
  input  gtsm_pkg::evt_t  evt_i,
  input  gtsm_pkg::cfg_t  cfg_i,
  output gtsm_pkg::res_t  res_o
);
  import gtsm_pkg::*;

  pos_e  pos_q, pos_d;
  last_e last_q, last_d;
  time_t last_time_q, last_time_d;
  time_t start_q, start_d;

  res_e  result;
  logic  want_open;
  pos_e  at_end, heading;
  time_t since_cmd, since_start;

  assign want_open   = (evt_i.command == CmdOpen);
  assign at_end      = want_open ? PosOpen : PosClosed;
  assign heading     = want_open ? PosOpening : PosClosing;
  assign since_cmd   = evt_i.now_time - last_time_q;
  assign since_start = evt_i.now_time - start_q;

  always_comb begin
    pos_d       = pos_q;
    last_d      = last_q;
    last_time_d = last_time_q;
    start_d     = start_q;
    result      = ResNone;
    case (evt_i.command)
      CmdOpen, CmdClose: begin
        if (pos_q == at_end || pos_q == heading) begin
          result = ResIdempotent;
        end else if (last_q != LastNone && since_cmd < cfg_i.min_cmd_spacing) begin
          result = ResThrottled;
        end else begin
          result      = ResAccepted;
          pos_d       = heading;
          last_d      = want_open ? LastOpen : LastClose;
          last_time_d = evt_i.now_time;
          start_d     = evt_i.now_time;
        end
      end
      CmdStatus: begin
        if (evt_i.fully_open) begin
          pos_d = PosOpen;
        end else if (pos_q == PosUnknown) begin
          pos_d = PosClosed;
        end else if (pos_q == PosOpen) begin
          // contact released: the gate has started to close
          pos_d   = PosClosing;
          start_d = evt_i.now_time;
        end
      end
      CmdTick: begin
        if ((pos_q == PosOpening || pos_q == PosClosing) &&
            since_start >= cfg_i.travel_timeout) begin
          pos_d = (pos_q == PosOpening) ? PosStopped : PosClosed;
        end
      end
      default: result = ResNone;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= PosUnknown;
      last_q      <= LastNone;
      last_time_q <= '0;
      start_q     <= '0;
    end else if (step_i) begin
      pos_q       <= pos_d;
      last_q      <= last_d;
      last_time_q <= last_time_d;
      start_q     <= start_d;
    end
  end

  assign res_o.cmd_result        = result;
  assign res_o.gate_state        = pos_d;
  assign res_o.last_command      = last_d;
  assign res_o.last_command_time = last_time_d;

endmodule

// ----- design/gate_travel_state_machine.sv -----
// ----------------------------------------------------------------------------
// gate_travel_state_machine: gate position tracker
// Takes open, close, status and tick events and reports the gate state.
// ----------------------------------------------------------------------------
//   channel | dir | payload                                         | use
//   evt_i   | in  | command, fully_open, now_time                   | events
//   res_o   | out | cmd_result, gate_state, last_command, last_..._time | results
//   cfg_i   | in  | index, value                                    | registers
//
// One event a cycle while the result is not stalled: an event word waits in the input register,
// where the state update runs, then moves into the result register.
// Result valid rises when the word moves into the result register.
// A stalled result holds the input register; the next word is still taken
// while the input register is empty. Reset clears state and valids.
// ----------------------------------------------------------------------------
module gate_travel_state_machine (
  input  logic        clk_i,
  input  logic        rst_ni,
  gtsm_chan_if.sink   evt_i,
  gtsm_chan_if.source res_o,
  gtsm_chan_if.sink   cfg_i
);
  import gtsm_pkg::*;

  logic in_vld_q, in_vld_d;
  evt_t evt_q;
  logic out_vld_q, out_vld_d;
  res_t res_q;
  res_t res_next;
  cfg_t cfg;
  logic advance;
  logic evt_take;

  // move the held event into the result register
  assign advance  = in_vld_q && (!out_vld_q || res_o.ready);
  assign evt_take = evt_i.valid && evt_i.ready;

  assign evt_i.ready = !in_vld_q || advance;
  assign cfg_i.ready = 1'b1;

  assign in_vld_d  = evt_take || (in_vld_q && !advance);
  assign out_vld_d = advance || (out_vld_q && !res_o.ready);

  gtsm_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_en_i (cfg_i.valid),
    .wr_i    (cfg_i.data),
    .cfg_o   (cfg)
  );

  gtsm_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .evt_i  (evt_q),
    .cfg_i  (cfg),
    .res_o  (res_next)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (evt_take) begin
      evt_q <= evt_i.data;
    end
    if (advance) begin
      res_q <= res_next;
    end
  end

  assign res_o.valid = out_vld_q;
  assign res_o.data  = res_q;

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for gate_travel_state_machine
// Drives directed and random open, close, status and tick events under
// several spacing and timeout settings and checks every result word
// against a cycle-free model of the gate position tracker.
// ----------------------------------------------------------------------------
module tb;

  import gtsm_pkg::*;

  localparam int unsigned StallLimit = 2000;
  // Indexes past the two registers: writes to them must be ignored
  localparam logic [CfgIdxW-1:0] CfgSpareLo = CfgIdxW'(2);
  localparam logic [CfgIdxW-1:0] CfgSpareHi = CfgIdxW'(3);

  logic clk_i = 1'b0;
  logic rst_ni;

  gtsm_chan_if #(.payload_t(evt_t))    evt_if ();
  gtsm_chan_if #(.payload_t(res_t))    res_if ();
  gtsm_chan_if #(.payload_t(cfg_wr_t)) cfg_if ();

  gate_travel_state_machine u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .evt_i  (evt_if),
    .res_o  (res_if),
    .cfg_i  (cfg_if)
  );

  always #5 clk_i = ~clk_i;

  // Gate model state and registers
  pos_e  model_pos          = PosUnknown;
  last_e model_last         = LastNone;
  time_t model_last_time    = '0;
  time_t model_travel_start = '0;
  time_t model_spacing      = MinSpacingRst;
  time_t model_timeout      = TravelTimeoutRst;

  evt_t pending_events[$];
  res_t expected_results[$];

  int unsigned idle_pct;
  int unsigned send_gap;
  int unsigned stall_left;
  int unsigned idle_cycles;
  int unsigned error_count;
  int unsigned events_sent;
  int unsigned results_checked;
  int unsigned settings_used;
  int unsigned result_counts[4];

  // Stimulus-side copies of the registers and the running clock stamp
  time_t gen_spacing = MinSpacingRst;
  time_t gen_timeout = TravelTimeoutRst;
  time_t stamp;
  time_t anchor;

  function automatic res_t gate_predict(evt_t ev);
    res_t  r;
    time_t gap;
    logic  want_open;
    r.cmd_result = ResNone;
    want_open = (ev.command == CmdOpen);
    case (ev.command)
      CmdOpen, CmdClose: begin
        gap = ev.now_time - model_last_time;
        if ((want_open && (model_pos == PosOpen || model_pos == PosOpening)) ||
            (!want_open && (model_pos == PosClosed || model_pos == PosClosing))) begin
          r.cmd_result = ResIdempotent;
        end else if (model_last != LastNone && gap < model_spacing) begin
          r.cmd_result = ResThrottled;
        end else begin
          r.cmd_result = ResAccepted;
          if (want_open) begin
            model_pos  = PosOpening;
            model_last = LastOpen;
          end else begin
            model_pos  = PosClosing;
            model_last = LastClose;
          end
          model_last_time    = ev.now_time;
          model_travel_start = ev.now_time;
        end
      end
      CmdStatus: begin
        if (ev.fully_open) begin
          model_pos = PosOpen;
        end else if (model_pos == PosUnknown) begin
          model_pos = PosClosed;
        end else if (model_pos == PosOpen) begin
          model_pos          = PosClosing;
          model_travel_start = ev.now_time;
        end
      end
      default: begin
        gap = ev.now_time - model_travel_start;
        if (gap >= model_timeout) begin
          if (model_pos == PosOpening) begin
            model_pos = PosStopped;
          end else if (model_pos == PosClosing) begin
            model_pos = PosClosed;
          end
        end
      end
    endcase
    r.gate_state        = model_pos;
    r.last_command      = model_last;
    r.last_command_time = model_last_time;
    return r;
  endfunction

  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    if (error_count < 100) begin
      $display("[%0t] MISMATCH result %0d %s: got 0x%0h, expected 0x%0h",
               $time, results_checked, field, got, want);
    end
    error_count++;
  endtask

  // Update the model on every accepted register write and event word
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_if.valid && cfg_if.ready) begin
        case (cfg_if.data.index)
          CfgMinSpacing:    model_spacing = cfg_if.data.value;
          CfgTravelTimeout: model_timeout = cfg_if.data.value;
          default: ;
        endcase
      end
      if (evt_if.valid && evt_if.ready) begin
        expected_results.push_back(gate_predict(evt_if.data));
        events_sent++;
      end
    end
  end

  // Event driver: hold the word until taken, insert bursts of idle cycles
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      evt_if.valid <= 1'b0;
      evt_if.data  <= '0;
      send_gap     <= 0;
    end else if (!evt_if.valid || evt_if.ready) begin
      if (send_gap != 0) begin
        evt_if.valid <= 1'b0;
        send_gap     <= send_gap - 1;
      end else if ($urandom_range(0, 99) < idle_pct) begin
        evt_if.valid <= 1'b0;
        send_gap     <= $urandom_range(0, 9);
      end else if (pending_events.size() != 0) begin
        evt_if.valid <= 1'b1;
        evt_if.data  <= pending_events.pop_front();
      end else begin
        evt_if.valid <= 1'b0;
      end
    end
  end

  // Result sink back-pressure
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
      stall_left   <= 0;
    end else if (stall_left != 0) begin
      res_if.ready <= 1'b0;
      stall_left   <= stall_left - 1;
    end else if ($urandom_range(0, 99) < idle_pct) begin
      res_if.ready <= 1'b0;
      stall_left   <= $urandom_range(0, 9);
    end else begin
      res_if.ready <= 1'b1;
    end
  end

  // Result checker
  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected word", res_if.data.last_command_time, '0);
      end else begin
        want = expected_results.pop_front();
        if (res_if.data.cmd_result !== want.cmd_result)
          report_mismatch("cmd_result", 32'(res_if.data.cmd_result),
                          32'(want.cmd_result));
        if (res_if.data.gate_state !== want.gate_state)
          report_mismatch("gate_state", 32'(res_if.data.gate_state),
                          32'(want.gate_state));
        if (res_if.data.last_command !== want.last_command)
          report_mismatch("last_command", 32'(res_if.data.last_command),
                          32'(want.last_command));
        if (res_if.data.last_command_time !== want.last_command_time)
          report_mismatch("last_command_time", res_if.data.last_command_time,
                          want.last_command_time);
        result_counts[want.cmd_result]++;
      end
      results_checked++;
    end
  end

  // Watchdog on cycles with no handshake anywhere
  always @(posedge clk_i) begin
    if ((evt_if.valid && evt_if.ready) || (res_if.valid && res_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= StallLimit) begin
      $display("[%0t] timeout: no handshake for %0d cycles", $time, StallLimit);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic write_reg(logic [CfgIdxW-1:0] index, time_t value);
    @(posedge clk_i);
    cfg_if.valid      <= 1'b1;
    cfg_if.data.index <= index;
    cfg_if.data.value <= value;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic apply_config(time_t spacing, time_t timeout);
    gen_spacing = spacing;
    gen_timeout = timeout;
    write_reg(CfgMinSpacing, spacing);
    write_reg(CfgTravelTimeout, timeout);
    settings_used++;
  endtask

  task automatic push_event(cmd_e command, logic fully_open, time_t now_time);
    evt_t ev;
    ev.command    = command;
    ev.fully_open = fully_open;
    ev.now_time   = now_time;
    pending_events.push_back(ev);
  endtask

  // Wait for the sender and the result queue to empty, then let the pipe settle
  task automatic wait_drained();
    do @(posedge clk_i);
    while (pending_events.size() != 0 || evt_if.valid || expected_results.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic queue_random(int unsigned count);
    evt_t        ev;
    int unsigned pick;
    int unsigned roll;
    for (int unsigned i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 25) begin
        ev.command = CmdOpen;
      end else if (pick < 50) begin
        ev.command = CmdClose;
      end else if (pick < 70) begin
        ev.command = CmdStatus;
      end else begin
        ev.command = CmdTick;
      end
      ev.fully_open = 1'($urandom_range(0, 1));
      roll = $urandom_range(0, 99);
      if (roll < 5) begin
        stamp = $urandom;
      end else if (roll < 40 && ev.command != CmdStatus) begin
        // land on either side of the spacing or timeout boundary
        if (ev.command == CmdTick) begin
          stamp = anchor + gen_timeout + time_t'($urandom_range(0, 2)) - time_t'(1);
        end else begin
          stamp = anchor + gen_spacing + time_t'($urandom_range(0, 2)) - time_t'(1);
        end
      end else if (roll < 60) begin
        stamp = stamp + time_t'($urandom_range(0, 3));
      end else if (roll < 85) begin
        stamp = stamp + time_t'($urandom_range(0, 2000));
      end else begin
        stamp = stamp + time_t'($urandom_range(0, 40000));
      end
      if (ev.command == CmdOpen || ev.command == CmdClose) begin
        anchor = stamp;
      end
      ev.now_time = stamp;
      pending_events.push_back(ev);
    end
  endtask

  initial begin
    cfg_if.valid = 1'b0;
    cfg_if.data  = '0;
    rst_ni       = 1'b0;
    idle_pct     = 10;
    stamp        = '0;
    anchor       = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    settings_used = 1;

    // Directed walk through every position under the reset settings
    push_event(CmdTick,   1'b0, 32'd0);
    push_event(CmdStatus, 1'b0, 32'd5);
    push_event(CmdClose,  1'b0, 32'd10);
    push_event(CmdOpen,   1'b1, 32'd20);
    push_event(CmdOpen,   1'b0, 32'd30);
    push_event(CmdClose,  1'b0, 32'd500);
    push_event(CmdClose,  1'b0, 32'd1020);
    push_event(CmdTick,   1'b1, 32'd31019);
    push_event(CmdTick,   1'b0, 32'd31020);
    push_event(CmdOpen,   1'b0, 32'd40000);
    push_event(CmdTick,   1'b0, 32'd70000);
    push_event(CmdOpen,   1'b0, 32'd70500);
    push_event(CmdStatus, 1'b1, 32'd71000);
    push_event(CmdStatus, 1'b0, 32'd72000);
    push_event(CmdTick,   1'b0, 32'd101999);
    push_event(CmdTick,   1'b0, 32'd102000);
    push_event(CmdStatus, 1'b1, 32'd102001);
    push_event(CmdClose,  1'b0, 32'd102002);
    push_event(CmdStatus, 1'b0, 32'd102100);
    push_event(CmdOpen,   1'b0, 32'd102500);
    push_event(CmdOpen,   1'b0, 32'd103002);
    push_event(CmdTick,   1'b0, 32'd133002);
    push_event(CmdStatus, 1'b0, 32'd133010);
    push_event(CmdClose,  1'b1, 32'd133020);
    push_event(CmdTick,   1'b1, 32'hFFFF_FFFF);
    push_event(CmdOpen,   1'b1, 32'h0000_0010);
    wait_drained();

    // Zero spacing and timeout: nothing throttles, first tick resolves travel
    apply_config('0, '0);
    idle_pct = 25;
    queue_random(150);
    wait_drained();

    apply_config('1, '1);
    idle_pct = 0;
    queue_random(150);
    wait_drained();

    apply_config(time_t'($urandom_range(50, 500)), time_t'($urandom_range(100, 2000)));
    write_reg(CfgSpareLo, $urandom);
    idle_pct = 15;
    queue_random(200);
    wait_drained();

    apply_config($urandom, $urandom);
    write_reg(CfgSpareHi, $urandom);
    idle_pct = 40;
    queue_random(150);
    wait_drained();

    // Closing stretch at full rate on the default settings
    apply_config(MinSpacingRst, TravelTimeoutRst);
    idle_pct = 0;
    queue_random(300);
    wait_drained();
    repeat (10) @(posedge clk_i);

    $display("Checked %0d results from %0d events over %0d register settings",
             results_checked, events_sent, settings_used);
    $display("Commands: %0d accepted, %0d idempotent, %0d throttled; %0d status or tick",
             result_counts[ResAccepted], result_counts[ResIdempotent],
             result_counts[ResThrottled], result_counts[ResNone]);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
design/gtsm_pkg.sv
design/gtsm_chan_if.sv
design/gtsm_cfg_regs.sv
design/gtsm_core.sv
design/gate_travel_state_machine.sv
tb/sv/tb.sv
